[hw/rtl/glcc_pkg.sv]
// Package for the gated long causal convolution block.
// Holds opcodes, fixed point widths and the Q16.16 rounding and saturation helpers.
// No dependencies.
package glcc_pkg;

   localparam int DEF_WIDTH   = 128;
   localparam int DEF_MAX_LEN = 1024;
   localparam int ACC_W       = 62;
   localparam int CAP_W       = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   typedef enum logic [2:0] {
      OPC_PROCESS    = 3'd0,
      OPC_KERNEL     = 3'd1,
      OPC_SHORT_TAP  = 3'd2,
      OPC_SHORT_BIAS = 3'd3,
      OPC_PASS_BIAS  = 3'd4,
      OPC_RESTART    = 3'd5
   } opcode_type;

   // floor((p + 2^15) / 2^16)
   function automatic logic signed [47:0] qround(input logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + 64'sd32768) >>> 16;
      return r[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(64'sd2147483647))
         return 32'sh7FFF_FFFF;
      else if (v < -ACC_W'(64'sd2147483648))
         return 32'sh8000_0000;
      else
         return v[31:0];
   endfunction

endpackage

[hw/rtl/gated_long_causal_convolution.sv]
// Gated long causal convolution: short filters, gate, direct long convolution.
// One request at a time; the long convolution does one multiply-accumulate per cycle
// over position + 1 history entries, so throughput is set by that single MAC unit.
// Synchronous active-high reset clears position, capacity (to 1024) and control;
// stores are undefined until written. Depends on glcc_pkg and glcc_ram.
module gated_long_causal_convolution #(
   parameter int WIDTH   = glcc_pkg::DEF_WIDTH,
   parameter int MAX_LEN = glcc_pkg::DEF_MAX_LEN
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // channel, branch, tap, coefficient, sample_out_gate, sample_key, sample_value
   input  logic [151:0] req_tdata,
   // opcode
   input  logic [2:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mixed
   output logic [31:0]  rsp_tdata,
   // status
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import glcc_pkg::*;

   localparam int ST_D  = 6 * WIDTH;
   localparam int TP_D  = 9 * WIDTH;
   localparam int OF_D  = 3 * WIDTH;
   localparam int PG_D  = WIDTH;
   localparam int HS_D  = MAX_LEN * WIDTH;
   localparam int ST_AW = (ST_D > 1) ? $clog2(ST_D) : 1;
   localparam int TP_AW = (TP_D > 1) ? $clog2(TP_D) : 1;
   localparam int OF_AW = (OF_D > 1) ? $clog2(OF_D) : 1;
   localparam int PG_AW = (PG_D > 1) ? $clog2(PG_D) : 1;
   localparam int HS_AW = (HS_D > 1) ? $clog2(HS_D) : 1;
   localparam int PW    = $clog2(MAX_LEN + 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_FILT   = 10'b00_0000_0010,
      S_FDRAIN = 10'b00_0000_0100,
      S_GATE   = 10'b00_0000_1000,
      S_GDRAIN = 10'b00_0001_0000,
      S_CONV   = 10'b00_0010_0000,
      S_CDRAIN = 10'b00_0100_0000,
      S_FIN    = 10'b00_1000_0000,
      S_YDRAIN = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      K_OFF  = 3'd0,
      K_X    = 3'd1,
      K_MEM  = 3'd2,
      K_GATE = 3'd3,
      K_PASS = 3'd4,
      K_CONV = 3'd5,
      K_FIN  = 3'd6
   } kind_type;

   // request fields
   logic [6:0]         in_ch;
   logic [1:0]         in_br;
   logic [9:0]         in_tap;
   logic signed [31:0] in_coef;
   logic               req_acc;
   logic               ch_ok;
   opcode_type         in_op;

   assign in_ch   = req_tdata[6:0];
   assign in_br   = req_tdata[8:7];
   assign in_tap  = req_tdata[18:9];
   assign in_coef = req_tdata[50:19];
   assign in_op   = opcode_type'(req_tuser);
   assign req_acc = req_tvalid && req_tready;
   assign ch_ok   = 32'(in_ch) < WIDTH;

   // registers
   state_type          state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [1:0]         b_ff, b_in;
   logic               first_ff, first_in;
   logic [PW-1:0]      lag_ff, lag_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [6:0]         ch_ff, ch_in;
   logic               last_ff, last_in;
   logic signed [31:0] xs_ff [0:2];
   logic signed [31:0] xs_in [0:2];
   logic signed [31:0] f_ff [0:2];
   logic signed [31:0] f_in [0:2];
   logic signed [31:0] gate_ff, gate_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] res_ff, res_in;
   logic               err_ff, err_in;
   logic [HS_AW-1:0]   hbase_ff, hbase_in;
   logic [HS_AW-1:0]   kaddr_ff, kaddr_in;
   logic [HS_AW-1:0]   haddr_ff, haddr_in;
   logic               v0_ff, v1_ff;
   kind_type           kind0_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   // issue stage
   logic               iss_v;
   kind_type           iss_kind;
   logic               acc_clr;
   logic               drained;

   // memory ports
   logic               st_we, tp_we, of_we, pg_we, kn_we, hs_we;
   logic [ST_AW-1:0]   st_wa, st_ra;
   logic [TP_AW-1:0]   tp_wa, tp_ra;
   logic [OF_AW-1:0]   of_wa, of_ra;
   logic [PG_AW-1:0]   pg_wa, pg_ra;
   logic [HS_AW-1:0]   kn_wa, kn_ra, hs_wa, hs_ra;
   logic [31:0]        st_wd, hs_wd;
   logic [31:0]        st_q, tp_q, of_q, pg_q, kn_q, hs_q;

   logic [31:0]        tp_base, st_rd_full, st_wr_full;
   logic [31:0]        lane;
   logic               cap_hit;
   logic               full;

   assign drained = !v0_ff && !v1_ff;
   assign lane    = 32'(b_ff) * 32'(WIDTH) + 32'(ch_ff);
   assign tp_base = lane * 32'd3;
   assign cap_hit = (32'(cap_ff) < 32'(MAX_LEN)) ? (32'(pos_ff) >= 32'(cap_ff))
                                                  : (32'(pos_ff) >= 32'(MAX_LEN));

   assign st_rd_full = ((step_ff == 2'd2) ? {31'd0, ~pos_ff[0]} : {31'd0, pos_ff[0]})
                       * 32'(3 * WIDTH) + lane;
   assign st_wr_full = 32'(pos_ff[0]) * 32'(3 * WIDTH) + lane;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      b_in     = b_ff;
      first_in = first_ff;
      lag_in   = lag_ff;
      pos_in   = pos_ff;
      ch_in    = ch_ff;
      last_in  = last_ff;
      xs_in    = xs_ff;
      f_in     = f_ff;
      gate_in  = gate_ff;
      y_in     = y_ff;
      res_in   = res_ff;
      err_in   = err_ff;
      hbase_in = hbase_ff;
      kaddr_in = kaddr_ff;
      haddr_in = haddr_ff;
      iss_v    = 1'b0;
      iss_kind = K_OFF;
      acc_clr  = 1'b0;
      full     = 1'b0;

      st_we = 1'b0;
      tp_we = 1'b0;
      of_we = 1'b0;
      pg_we = 1'b0;
      kn_we = 1'b0;
      hs_we = 1'b0;
      st_wa = st_wr_full[ST_AW-1:0];
      st_wd = xs_ff[b_ff];
      tp_wa = TP_AW'((32'(in_br) * 32'(WIDTH) + 32'(in_ch)) * 32'd3 + 32'(in_tap));
      of_wa = OF_AW'(32'(in_br) * 32'(WIDTH) + 32'(in_ch));
      pg_wa = PG_AW'(in_ch);
      kn_wa = HS_AW'(32'(in_tap) * 32'(WIDTH) + 32'(in_ch));
      hs_wa = hbase_ff;
      hs_wd = gate_ff;
      st_ra = st_rd_full[ST_AW-1:0];
      tp_ra = TP_AW'(tp_base + 32'(2'd3 - step_ff));
      of_ra = lane[OF_AW-1:0];
      pg_ra = PG_AW'(ch_ff);
      kn_ra = kaddr_ff;
      hs_ra = haddr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (in_op)
                  OPC_RESTART: pos_in = '0;
                  OPC_KERNEL: kn_we = ch_ok && (32'(in_tap) < 32'(MAX_LEN));
                  OPC_SHORT_TAP: tp_we = ch_ok && (in_br <= 2'd2) && (in_tap <= 10'd2);
                  OPC_SHORT_BIAS: of_we = ch_ok && (in_br <= 2'd2);
                  OPC_PASS_BIAS: pg_we = ch_ok;
                  OPC_PROCESS: begin
                     if (ch_ok) begin
                        ch_in    = in_ch;
                        last_in  = req_tlast;
                        xs_in[0] = req_tdata[82:51];
                        xs_in[1] = req_tdata[114:83];
                        xs_in[2] = req_tdata[146:115];
                        hbase_in = HS_AW'(32'(pos_ff) * 32'(WIDTH) + 32'(in_ch));
                        b_in     = 2'd0;
                        step_in  = 2'd0;
                        if (cap_hit) begin
                           full     = 1'b1;
                           res_in   = '0;
                           err_in   = 1'b1;
                           state_in = S_DONE;
                        end else begin
                           state_in = S_FILT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FILT: begin
            unique case (step_ff)
               2'd0: begin iss_v = 1'b1;                       iss_kind = K_OFF; end
               2'd1: begin iss_v = 1'b1;                       iss_kind = K_X;   end
               2'd2: begin iss_v = pos_ff >= PW'(1);           iss_kind = K_MEM; end
               default: begin iss_v = pos_ff >= PW'(2);        iss_kind = K_MEM; end
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3)
               state_in = S_FDRAIN;
         end
         S_FDRAIN: begin
            if (drained) begin
               f_in[b_ff] = sat32(acc_ff);
               st_we      = 1'b1;
               acc_clr    = 1'b1;
               step_in    = 2'd0;
               if (b_ff == 2'd2) begin
                  state_in = S_GATE;
               end else begin
                  b_in     = b_ff + 2'd1;
                  state_in = S_FILT;
               end
            end
         end
         S_GATE: begin
            iss_v    = 1'b1;
            iss_kind = K_GATE;
            state_in = S_GDRAIN;
         end
         S_GDRAIN: begin
            if (drained) begin
               gate_in  = sat32(acc_ff);
               acc_clr  = 1'b1;
               first_in = 1'b1;
               lag_in   = '0;
               kaddr_in = HS_AW'(ch_ff);
               haddr_in = hbase_ff;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            hs_we = first_ff;
            if (first_ff) begin
               iss_v    = 1'b1;
               iss_kind = K_PASS;
               first_in = 1'b0;
            end else begin
               iss_v    = 1'b1;
               iss_kind = K_CONV;
               kaddr_in = kaddr_ff + HS_AW'(WIDTH);
               haddr_in = haddr_ff - HS_AW'(WIDTH);
               lag_in   = lag_ff + PW'(1);
               if (lag_ff == pos_ff)
                  state_in = S_CDRAIN;
            end
         end
         S_CDRAIN: begin
            if (drained) begin
               y_in     = sat32(acc_ff);
               acc_clr  = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            iss_v    = 1'b1;
            iss_kind = K_FIN;
            state_in = S_YDRAIN;
         end
         S_YDRAIN: begin
            if (drained) begin
               res_in   = sat32(acc_ff);
               err_in   = 1'b0;
               acc_clr  = 1'b1;
               if (last_ff)
                  pos_in = pos_ff + PW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // gate is written in the pass-term cycle, before any history read of this position

   // MAC datapath: issue -> memory read -> multiply -> accumulate
   logic signed [31:0] op_a, op_b;

   always_comb begin
      case (kind0_ff)
         K_OFF:   begin op_a = of_q;       op_b = Q_ONE;    end
         K_X:     begin op_a = xs_ff[b_ff]; op_b = tp_q;    end
         K_MEM:   begin op_a = st_q;       op_b = tp_q;     end
         K_GATE:  begin op_a = f_ff[2];    op_b = f_ff[1];  end
         K_PASS:  begin op_a = pg_q;       op_b = gate_ff;  end
         K_CONV:  begin op_a = kn_q;       op_b = hs_q;     end
         K_FIN:   begin op_a = y_ff;       op_b = f_ff[0];  end
         default: begin op_a = '0;         op_b = '0;       end
      endcase
   end

   always_comb begin
      if (acc_clr)
         acc_in = '0;
      else if (v1_ff)
         acc_in = acc_ff + ACC_W'(qround(prod_ff));
      else
         acc_in = acc_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
         rsp_user_in  = err_ff;
      end
   end

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && !csr_paddr[2])
         cap_in = csr_pwdata[CAP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         cap_ff       <= CAP_RESET;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cap_ff       <= cap_in;
         v0_ff        <= iss_v;
         v1_ff        <= v0_ff;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      b_ff        <= b_in;
      first_ff    <= first_in;
      lag_ff      <= lag_in;
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      xs_ff       <= xs_in;
      f_ff        <= f_in;
      gate_ff     <= gate_in;
      y_ff        <= y_in;
      res_ff      <= res_in;
      err_ff      <= err_in;
      hbase_ff    <= hbase_in;
      kaddr_ff    <= kaddr_in;
      haddr_ff    <= haddr_in;
      kind0_ff    <= iss_kind;
      prod_ff     <= op_a * op_b;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   glcc_ram #(.DATA_W(32), .DEPTH(ST_D), .AW(ST_AW)) u_short_store (
      .clock(clock), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_q));
   glcc_ram #(.DATA_W(32), .DEPTH(TP_D), .AW(TP_AW)) u_short_taps (
      .clock(clock), .we(tp_we), .waddr(tp_wa), .wdata(in_coef), .raddr(tp_ra), .rdata(tp_q));
   glcc_ram #(.DATA_W(32), .DEPTH(OF_D), .AW(OF_AW)) u_short_offsets (
      .clock(clock), .we(of_we), .waddr(of_wa), .wdata(in_coef), .raddr(of_ra), .rdata(of_q));
   glcc_ram #(.DATA_W(32), .DEPTH(PG_D), .AW(PG_AW)) u_pass_gain (
      .clock(clock), .we(pg_we), .waddr(pg_wa), .wdata(in_coef), .raddr(pg_ra), .rdata(pg_q));
   glcc_ram #(.DATA_W(32), .DEPTH(HS_D), .AW(HS_AW)) u_long_kernel (
      .clock(clock), .we(kn_we), .waddr(kn_wa), .wdata(in_coef), .raddr(kn_ra), .rdata(kn_q));
   glcc_ram #(.DATA_W(32), .DEPTH(HS_D), .AW(HS_AW)) u_gate_history (
      .clock(clock), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_q));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(cap_ff);

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!v0_ff && !v1_ff))
      else $error("MAC pipeline busy while idle");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == 32'd0))
      else $error("context-full response carries data");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (req_acc && in_op == OPC_PROCESS && ch_ok && !full) |=> (acc_ff == '0 && state_ff == S_FILT))
      else $error("filter started with dirty accumulator");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= 32'(MAX_LEN))
      else $error("position beyond max length");

   a_full_no_adv: assert property (@(posedge clock) disable iff (reset)
      full |=> (pos_ff == $past(pos_ff)))
      else $error("rejected request moved position");
endmodule

[hw/rtl/glcc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glcc_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 128,
   parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [AW-1:0]     raddr,
   output logic [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
